FILE: design/ckvt_pkg.sv
package ckvt_pkg;

  localparam int unsigned MaxRes = 4;

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_PAIR  = 2'd2;
  localparam logic [1:0] KIND_LINE  = 2'd3;

  localparam logic [7:0] QUOTE_CH  = 8'h22;
  localparam logic [7:0] EQUALS_CH = 8'h3D;
  localparam logic [7:0] DASH_CH   = 8'h2D;
  localparam logic [7:0] SPACE_CH  = 8'h20;
  localparam logic [7:0] TAB_CH    = 8'h09;
  localparam logic [7:0] CR_CH     = 8'h0D;

  typedef struct packed {
    logic       in_token;
    logic       token_quoted;
    logic       inside_quotes;
    logic       seen_split;
    logic       value_quoted;
    logic       at_value_start;
    logic       held_quote;
    logic [1:0] name_length;
    logic       name_all_dash;
    logic       stopped;
    logic       any_token;
  } tok_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       has_value;
    logic       is_stop;
    logic       empty_line;
  } tok_res_t;

  localparam tok_state_t TOK_RESET = '{
    in_token:       1'b0,
    token_quoted:   1'b0,
    inside_quotes:  1'b0,
    seen_split:     1'b0,
    value_quoted:   1'b0,
    at_value_start: 1'b0,
    held_quote:     1'b0,
    name_length:    2'd0,
    name_all_dash:  1'b1,
    stopped:        1'b0,
    any_token:      1'b0
  };

  function automatic logic is_blank(logic [7:0] c);
    return (c == SPACE_CH) || ((c >= TAB_CH) && (c <= CR_CH));
  endfunction

  // Result for a name or value byte.
  function automatic tok_res_t put_res(tok_state_t s, logic [7:0] c);
    tok_res_t r;
    r = '0;
    r.kind = s.seen_split ? KIND_VALUE : KIND_NAME;
    r.ch   = c;
    return r;
  endfunction

  function automatic tok_state_t put_state(tok_state_t s, logic [7:0] c);
    tok_state_t t;
    t = s;
    if (!s.seen_split) begin
      if (s.name_length != 2'd3) begin
        t.name_length = s.name_length + 2'd1;
      end
      if (c != DASH_CH) begin
        t.name_all_dash = 1'b0;
      end
    end
    return t;
  endfunction

  function automatic logic close_stop(tok_state_t s);
    return !s.seen_split && (s.name_length == 2'd2) && s.name_all_dash;
  endfunction

  function automatic tok_res_t close_res(tok_state_t s);
    tok_res_t r;
    r = '0;
    r.kind      = KIND_PAIR;
    r.has_value = s.seen_split;
    r.is_stop   = close_stop(s);
    return r;
  endfunction

  // Clear per-token flags; keep line-level flags.
  function automatic tok_state_t close_state(tok_state_t s);
    tok_state_t t;
    t = TOK_RESET;
    t.any_token = s.any_token;
    t.stopped   = s.stopped | close_stop(s);
    return t;
  endfunction

endpackage

FILE: design/cmdline_key_value_tokenizer.sv
// Command-line key/value tokenizer.
// Input channel (in_valid/in_ready): one command-line byte per transfer,
// char_in plus line_end on the final byte of a line.
// Output channel (out_valid/out_ready): a stream of results, each a name
// byte, value byte, end of pair or end of line; last marks the final result
// caused by one input byte.
// Each input byte causes zero to four results. The results of an accepted
// byte are computed in the cycle of the transfer and held in a four-entry
// result group; the first one is presented the next cycle.
// The group drains one result per cycle while out_ready is high; bytes
// with at most one result flow at one per cycle while the receiver is
// ready. The next byte is taken while the group is empty or in the cycle
// its last result is transferred, so the single group register sets the rate.
// Reset (rst, synchronous) clears the tokenizer state and empties the group.
// When the receiver stalls, the presented result holds and in_ready stays
// low until the group's final result is transferred.
module cmdline_key_value_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] out_char,
  output logic       has_value,
  output logic       is_stop,
  output logic       empty_line,
  output logic       last
);

  ckvt_pkg::tok_state_t st;
  ckvt_pkg::tok_state_t st_next;
  ckvt_pkg::tok_res_t   res_next [ckvt_pkg::MaxRes];
  logic [2:0]           cnt_next;

  ckvt_pkg::tok_res_t   grp [ckvt_pkg::MaxRes];
  logic [2:0]           grp_cnt;
  logic [1:0]           grp_idx;

  logic take;
  logic done;
  logic is_quote;
  logic fire_in;
  logic fire_out;

  assign is_quote = (char_in == ckvt_pkg::QUOTE_CH);

  always_comb begin
    st_next = st;
    cnt_next = '0;
    take = 1'b0;
    done = 1'b0;
    for (int i = 0; i < ckvt_pkg::MaxRes; i++) begin
      res_next[i] = '0;
    end

    if (!st.stopped && (char_in != 8'd0)) begin
      if (!st.in_token) begin
        if (!ckvt_pkg::is_blank(char_in)) begin
          st_next.in_token = 1'b1;
          st_next.any_token = 1'b1;
          if (is_quote) begin
            st_next.token_quoted = 1'b1;
            st_next.inside_quotes = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
      end else if (ckvt_pkg::is_blank(char_in) && !st.inside_quotes) begin
        res_next[cnt_next[1:0]] = ckvt_pkg::close_res(st_next);
        cnt_next = cnt_next + 3'd1;
        st_next = ckvt_pkg::close_state(st_next);
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      // Release a held quote now that another token byte follows.
      if (st_next.held_quote) begin
        st_next.held_quote = 1'b0;
        res_next[cnt_next[1:0]] = ckvt_pkg::put_res(st_next, ckvt_pkg::QUOTE_CH);
        cnt_next = cnt_next + 3'd1;
        st_next = ckvt_pkg::put_state(st_next, ckvt_pkg::QUOTE_CH);
      end
      if (st_next.at_value_start) begin
        st_next.at_value_start = 1'b0;
        if (is_quote) begin
          st_next.value_quoted = 1'b1;
          st_next.inside_quotes = !st_next.inside_quotes;
          done = 1'b1;
        end
      end
      if (!done && !st_next.seen_split && (char_in == ckvt_pkg::EQUALS_CH)
          && (st_next.name_length != 2'd0)) begin
        st_next.seen_split = 1'b1;
        st_next.at_value_start = 1'b1;
        done = 1'b1;
      end
      if (!done && is_quote) begin
        st_next.inside_quotes = !st_next.inside_quotes;
        if (st_next.token_quoted || st_next.value_quoted) begin
          st_next.held_quote = 1'b1;
          done = 1'b1;
        end
      end
      if (!done) begin
        res_next[cnt_next[1:0]] = ckvt_pkg::put_res(st_next, char_in);
        cnt_next = cnt_next + 3'd1;
        st_next = ckvt_pkg::put_state(st_next, char_in);
      end
    end

    if (line_end) begin
      if (st_next.in_token) begin
        res_next[cnt_next[1:0]] = ckvt_pkg::close_res(st_next);
        cnt_next = cnt_next + 3'd1;
        st_next = ckvt_pkg::close_state(st_next);
      end
      res_next[cnt_next[1:0]] = '{
        kind:       ckvt_pkg::KIND_LINE,
        ch:         8'd0,
        has_value:  1'b0,
        is_stop:    1'b0,
        empty_line: !st_next.any_token
      };
      cnt_next = cnt_next + 3'd1;
      st_next = ckvt_pkg::TOK_RESET;
    end
  end

  assign out_valid = (grp_cnt != 3'd0);
  assign last      = out_valid && ({1'b0, grp_idx} == (grp_cnt - 3'd1));
  assign fire_out  = out_valid && out_ready;
  assign in_ready  = !out_valid || (fire_out && last);
  assign fire_in   = in_valid && in_ready;

  assign kind       = grp[grp_idx].kind;
  assign out_char   = grp[grp_idx].ch;
  assign has_value  = grp[grp_idx].has_value;
  assign is_stop    = grp[grp_idx].is_stop;
  assign empty_line = grp[grp_idx].empty_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ckvt_pkg::TOK_RESET;
      grp_cnt <= '0;
      grp_idx <= '0;
    end else if (fire_in) begin
      st      <= st_next;
      grp_cnt <= cnt_next;
      grp_idx <= '0;
    end else if (fire_out) begin
      if (last) begin
        grp_cnt <= '0;
        grp_idx <= '0;
      end else begin
        grp_idx <= grp_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      for (int i = 0; i < ckvt_pkg::MaxRes; i++) begin
        grp[i] <= res_next[i];
      end
    end
  end

  a_group_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |=> out_valid)
    else $error("result group dropped before its last result");

  a_group_size: assert property (@(posedge clk) disable iff (rst)
    grp_cnt <= 3'(ckvt_pkg::MaxRes))
    else $error("result group count out of range");

  a_line_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == ckvt_pkg::KIND_LINE) |-> last)
    else $error("end of line is not the final result");

  a_stop_closed: assert property (@(posedge clk) disable iff (rst)
    st.stopped |-> !st.in_token)
    else $error("token open after stop");

endmodule

FILE: tb/sv/cmdline_key_value_tokenizer_test.sv
`timescale 1ns / 100ps

module cmdline_key_value_tokenizer_test;

  localparam logic [7:0] NUL_CH = 8'h00;
  localparam int RandomBytes = 410;
  localparam int HoldOffCycles = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic       le;
  } cmd_byte_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       has_value;
    logic       is_stop;
    logic       empty_line;
    logic       last;
  } token_res_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_in = 8'h00;
  logic       line_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic       has_value;
  logic       is_stop;
  logic       empty_line;
  logic       last;

  logic       hold_off = 1'b0;
  logic [1:0] idle_phase = 2'd0;

  cmd_byte_t  cmdline_bytes[$];
  token_res_t expected_tokens[$];
  token_res_t step_tokens[$];

  int n_total = 0;
  int n_acc = 0;
  int n_checked = 0;
  int n_fail = 0;
  int n_lines = 0;
  int n_stops = 0;

  // Tokenizer state of the predictor.
  logic       tk_open = 1'b0;
  logic       tk_lead_quote = 1'b0;
  logic       quote_open = 1'b0;
  logic       split_seen = 1'b0;
  logic       val_lead_quote = 1'b0;
  logic       val_start = 1'b0;
  logic       quote_held = 1'b0;
  logic [1:0] name_cnt = 2'd0;
  logic       name_dashes = 1'b1;
  logic       line_stopped = 1'b0;
  logic       line_had_token = 1'b0;

  cmdline_key_value_tokenizer i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .line_end   (line_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_char   (out_char),
    .has_value  (has_value),
    .is_stop    (is_stop),
    .empty_line (empty_line),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void add_token(logic [1:0] k, logic [7:0] c, logic hv, logic st,
                                    logic em);
    token_res_t r;
    r = '{kind: k, ch: c, has_value: hv, is_stop: st, empty_line: em, last: 1'b0};
    step_tokens.push_back(r);
  endfunction

  function automatic void emit_byte(logic [7:0] c);
    if (split_seen) begin
      add_token(ckvt_pkg::KIND_VALUE, c, 1'b0, 1'b0, 1'b0);
    end else begin
      add_token(ckvt_pkg::KIND_NAME, c, 1'b0, 1'b0, 1'b0);
      if (name_cnt != 2'd3) begin
        name_cnt = name_cnt + 2'd1;
      end
      if (c != ckvt_pkg::DASH_CH) begin
        name_dashes = 1'b0;
      end
    end
  endfunction

  function automatic void clear_token();
    tk_open = 1'b0;
    tk_lead_quote = 1'b0;
    quote_open = 1'b0;
    split_seen = 1'b0;
    val_lead_quote = 1'b0;
    val_start = 1'b0;
    quote_held = 1'b0;
    name_cnt = 2'd0;
    name_dashes = 1'b1;
  endfunction

  function automatic void close_pair();
    logic stop;
    stop = !split_seen && name_cnt == 2'd2 && name_dashes;
    add_token(ckvt_pkg::KIND_PAIR, NUL_CH, split_seen, stop, 1'b0);
    clear_token();
    if (stop) begin
      line_stopped = 1'b1;
      n_stops++;
    end
  endfunction

  function automatic void token_byte_in(logic [7:0] c);
    if (quote_held) begin
      quote_held = 1'b0;
      emit_byte(ckvt_pkg::QUOTE_CH);
    end
    if (val_start) begin
      val_start = 1'b0;
      if (c == ckvt_pkg::QUOTE_CH) begin
        val_lead_quote = 1'b1;
        quote_open = !quote_open;
        return;
      end
    end
    if (!split_seen && c == ckvt_pkg::EQUALS_CH && name_cnt != 2'd0) begin
      split_seen = 1'b1;
      val_start = 1'b1;
      return;
    end
    if (c == ckvt_pkg::QUOTE_CH) begin
      quote_open = !quote_open;
      // hold a possible closing quote until the token goes on
      if (tk_lead_quote || val_lead_quote) begin
        quote_held = 1'b1;
        return;
      end
    end
    emit_byte(c);
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic le);
    logic blank;
    blank = (c == ckvt_pkg::SPACE_CH) || (c >= ckvt_pkg::TAB_CH && c <= ckvt_pkg::CR_CH);
    step_tokens.delete();
    if (!line_stopped && c != NUL_CH) begin
      if (!tk_open) begin
        if (!blank) begin
          tk_open = 1'b1;
          line_had_token = 1'b1;
          if (c == ckvt_pkg::QUOTE_CH) begin
            tk_lead_quote = 1'b1;
            quote_open = 1'b1;
          end else begin
            token_byte_in(c);
          end
        end
      end else if (blank && !quote_open) begin
        close_pair();
      end else begin
        token_byte_in(c);
      end
    end
    if (le) begin
      if (tk_open) begin
        close_pair();
      end
      add_token(ckvt_pkg::KIND_LINE, NUL_CH, 1'b0, 1'b0, !line_had_token);
      clear_token();
      line_stopped = 1'b0;
      line_had_token = 1'b0;
      n_lines++;
    end
    if (step_tokens.size() > 0) begin
      step_tokens[step_tokens.size() - 1].last = 1'b1;
    end
    foreach (step_tokens[i]) begin
      expected_tokens.push_back(step_tokens[i]);
    end
  endfunction

  function automatic void push_byte(logic [7:0] c, logic le);
    cmd_byte_t b;
    b = '{ch: c, le: le};
    cmdline_bytes.push_back(b);
    n_total++;
  endfunction

  task automatic push_str(string s, bit end_line);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], end_line && i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] blank_byte();
    if ($urandom_range(1) == 0) begin
      return ckvt_pkg::SPACE_CH;
    end
    return 8'(ckvt_pkg::TAB_CH + $urandom_range(4));
  endfunction

  function automatic logic [7:0] token_char();
    case ($urandom_range(9))
      0: return ckvt_pkg::QUOTE_CH;
      1: return ckvt_pkg::EQUALS_CH;
      2: return ckvt_pkg::DASH_CH;
      3: return 8'($urandom_range(255));
      default: return 8'($urandom_range(8'h61, 8'h7a));  // lowercase letter
    endcase
  endfunction

  task automatic push_random_line();
    logic [7:0] text[$];
    int n_tok;
    if ($urandom_range(9) == 0) begin
      // noise line
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(255)));
    end else begin
      n_tok = $urandom_range(4);
      for (int t = 0; t < n_tok; t++) begin
        if (t > 0 || $urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 2)) text.push_back(blank_byte());
        end
        if ($urandom_range(7) == 0) begin
          text.push_back(ckvt_pkg::DASH_CH);
          text.push_back(ckvt_pkg::DASH_CH);
        end else begin
          if ($urandom_range(2) == 0) text.push_back(ckvt_pkg::QUOTE_CH);
          repeat ($urandom_range(1, 3)) text.push_back(token_char());
          if ($urandom_range(1) == 0) begin
            text.push_back(ckvt_pkg::EQUALS_CH);
            if ($urandom_range(2) == 0) text.push_back(ckvt_pkg::QUOTE_CH);
            repeat ($urandom_range(3)) text.push_back(token_char());
          end
          if ($urandom_range(2) == 0) text.push_back(ckvt_pkg::QUOTE_CH);
        end
      end
      if (text.size() == 0 || $urandom_range(3) == 0) begin
        text.push_back($urandom_range(1) ? blank_byte() : NUL_CH);
      end
    end
    foreach (text[i]) begin
      push_byte(text[i], i == text.size() - 1);
    end
  endtask

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      n_fail++;
    end
  endfunction

  // Driver: offer the next byte, hold it until the transfer.
  always @(posedge clk) begin
    cmd_byte_t b;
    int src_idle;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tokenize_byte(char_in, line_end);
        n_acc <= n_acc + 1;
      end
      if (n_acc < n_total / 3) begin
        idle_phase <= 2'd0;
      end else if (n_acc < 2 * n_total / 3) begin
        idle_phase <= 2'd1;
      end else begin
        idle_phase <= 2'd2;
      end
      src_idle = (idle_phase == 2'd0) ? 20 : (idle_phase == 2'd1) ? 50 : 0;
      if (!in_valid || in_ready) begin
        if (cmdline_bytes.size() > 0 && $urandom_range(99) >= src_idle) begin
          b = cmdline_bytes.pop_front();
          in_valid <= 1'b1;
          char_in <= b.ch;
          line_end <= b.le;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each transferred result against the oldest prediction.
  always @(posedge clk) begin
    token_res_t e;
    int snk_idle;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("result with no prediction: kind %0d, char %0d", kind, out_char);
          n_fail++;
        end else begin
          e = expected_tokens.pop_front();
          check_field("kind", e.kind, kind);
          check_field("out_char", e.ch, out_char);
          check_field("has_value", e.has_value, has_value);
          check_field("is_stop", e.is_stop, is_stop);
          check_field("empty_line", e.empty_line, empty_line);
          check_field("last", e.last, last);
          n_checked++;
        end
      end
      snk_idle = (idle_phase == 2'd0) ? 50 : (idle_phase == 2'd1) ? 20 : 0;
      out_ready <= !hold_off && ($urandom_range(99) >= snk_idle);
    end
  end

  // Stall the output for a long stretch so the input backs up.
  initial begin
    while (n_acc < 150) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    // zero byte ends an empty line; blanks only
    push_byte(NUL_CH, 1'b1);
    push_str(" \t", 1'b1);
    // leading equals is a name byte; value of a lone quote is empty
    push_str("=x=\"", 1'b1);
    // quoted token with a blank inside, held quote before the split
    push_str("\"k b\"=1", 1'b1);
    // stop pair, rest of the line dropped
    push_str("-- z", 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(NUL_CH, 1'b0);
    push_byte(8'h80, 1'b1);
    // quoted value, closing quote dropped at line end
    push_str("a=\"v\"", 1'b1);
    while (n_total < RandomBytes) begin
      push_random_line();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (n_acc < n_total) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d lines; checked %0d results, %0d stop pairs.",
             n_acc, n_lines, n_checked, n_stops);
    if (n_fail == 0 && expected_tokens.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ckvt_pkg.sv
design/cmdline_key_value_tokenizer.sv
tb/sv/cmdline_key_value_tokenizer_test.sv
